// File: hdl/gmcc_pkg.sv
// Shared types, codes and helpers of the grid map coordinate converter.
package gmcc_pkg;

   localparam int CELL_BITS_DEF = 16;
   localparam int NUM_W = 36;
   localparam int REM_W = 31;
   localparam int TRIG_SHIFT = 14;

   typedef enum logic [2:0] {
      CMD_W2C_CLAMP   = 3'd0,
      CMD_W2C_RAW     = 3'd1,
      CMD_C2W         = 3'd2,
      CMD_WORLD_TEST  = 3'd3,
      CMD_CELL_TEST   = 3'd4
   } command_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X   = 3'd0,
      REG_ORIGIN_Y   = 3'd1,
      REG_SIN_ANGLE  = 3'd2,
      REG_COS_ANGLE  = 3'd3,
      REG_RESOLUTION = 3'd4,
      REG_MAP_WIDTH  = 3'd5,
      REG_MAP_HEIGHT = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [15:0] sin_angle;
      logic signed [15:0] cos_angle;
      logic [30:0]        resolution;
      logic [15:0]        map_width;
      logic [15:0]        map_height;
   } cfg_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [NUM_W-1:0] num;
   } lane_type;

   typedef struct packed {
      logic               valid;
      logic [2:0]         cmd;
      logic               sign_x;
      logic               sign_y;
      logic               inside_cell;
      logic signed [31:0] owx;
      logic signed [31:0] owy;
      lane_type           lane_x;
      lane_type           lane_y;
   } stage_type;

   function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
      logic signed [31:0] r;
      if (v > 52'sh0_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -52'sh0_0000_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

endpackage

// File: hdl/grid_map_coordinate_converter.sv
// Top level of the grid map coordinate converter: configuration registers and cell chain.
// Fully pipelined: one request per cycle, never busy outside reset, and every request
// yields its result on the rsp_ ports, held for one cycle under rsp_valid. The path
// runs through three front stages (rotation products, origin offsets, cell to world
// rotation), a chain of 36 division cells that each produce one quotient bit of the
// division by the resolution, and one result register. The receiver cannot stall, so
// results must be taken when rsp_valid is high.
module grid_map_coordinate_converter #(
   parameter int CELL_BITS = gmcc_pkg::CELL_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_world_x,
   input  logic signed [31:0] req_world_y,
   input  logic [15:0]        req_cell_x,
   input  logic [15:0]        req_cell_y,
   output logic               rsp_valid,
   output logic signed [39:0] rsp_out_cell_x,
   output logic signed [39:0] rsp_out_cell_y,
   output logic signed [31:0] rsp_out_world_x,
   output logic signed [31:0] rsp_out_world_y,
   output logic               rsp_inside_map,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import gmcc_pkg::*;

   cfg_type   cfg_ff;
   stage_type chain [0:NUM_W];

   assign busy = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
         cfg_ff.sin_angle  <= '0;
         cfg_ff.cos_angle  <= 16'sd16384;
         cfg_ff.resolution <= 31'd65536;
         cfg_ff.map_width  <= 16'd1;
         cfg_ff.map_height <= 16'd1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ORIGIN_X:   cfg_ff.origin_x <= csr_wdata;
            REG_ORIGIN_Y:   cfg_ff.origin_y <= csr_wdata;
            REG_SIN_ANGLE:  cfg_ff.sin_angle <= csr_wdata[15:0];
            REG_COS_ANGLE:  cfg_ff.cos_angle <= csr_wdata[15:0];
            REG_RESOLUTION: cfg_ff.resolution <= (csr_wdata[30:0] == 31'd0) ? 31'd1
                                                                            : csr_wdata[30:0];
            REG_MAP_WIDTH:  cfg_ff.map_width <= csr_wdata[15:0];
            REG_MAP_HEIGHT: cfg_ff.map_height <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   gmcc_front #(.CELL_BITS(CELL_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (start & ~busy),
      .in_cmd   (req_command),
      .in_wx    (req_world_x),
      .in_wy    (req_world_y),
      .in_cx    (req_cell_x),
      .in_cy    (req_cell_y),
      .head     (chain[0])
   );

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      gmcc_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .resolution (cfg_ff.resolution),
         .stage_in   (chain[i]),
         .stage_out  (chain[i+1])
      );
   end

   gmcc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .tail            (chain[NUM_W]),
      .rsp_valid       (rsp_valid),
      .rsp_out_cell_x  (rsp_out_cell_x),
      .rsp_out_cell_y  (rsp_out_cell_y),
      .rsp_out_world_x (rsp_out_world_x),
      .rsp_out_world_y (rsp_out_world_y),
      .rsp_inside_map  (rsp_inside_map)
   );

endmodule

// File: hdl/gmcc_front.sv
// Front pipeline: rotations, origin offsets, cell to world path and divider setup.
module gmcc_front #(
   parameter int CELL_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  gmcc_pkg::cfg_type   cfg,
   input  logic                in_valid,
   input  logic [2:0]          in_cmd,
   input  logic signed [31:0]  in_wx,
   input  logic signed [31:0]  in_wy,
   input  logic [15:0]         in_cx,
   input  logic [15:0]         in_cy,
   output gmcc_pkg::stage_type head
);
   import gmcc_pkg::*;

   localparam int CW = (CELL_BITS < 16) ? CELL_BITS : 16;

   logic [CW-1:0] celx, cely;
   logic signed [17:0] hm;

   logic                v1_ff, v2_ff, v3_ff;
   logic [2:0]          c1_ff, c2_ff, c3_ff;
   logic                ins1_ff, ins2_ff, ins3_ff;
   logic signed [47:0]  p_xc_ff, p_ys_ff, p_xs_ff, p_yc_ff;
   logic [CW+30:0]      mx_ff;
   logic signed [49:0]  my_ff;
   logic signed [35:0]  nx_ff, ny_ff;
   logic signed [49:0]  vx_ff, vy_ff;
   logic [NUM_W-1:0]    mag_x_ff, mag_y_ff;
   logic                sx_ff, sy_ff;
   logic signed [65:0]  q_xc_ff, q_ys_ff, q_yc_ff, q_xs_ff;
   logic signed [51:0]  wsum_x, wsum_y;

   assign celx = in_cx[CW-1:0];
   assign cely = in_cy[CW-1:0];
   assign hm = $signed({2'b00, cfg.map_height}) - 18'sd1 - $signed(18'({2'b00, 16'(cely)}));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      c1_ff   <= in_cmd;
      p_xc_ff <= in_wx * cfg.cos_angle;
      p_ys_ff <= in_wy * cfg.sin_angle;
      p_xs_ff <= in_wx * cfg.sin_angle;
      p_yc_ff <= in_wy * cfg.cos_angle;
      mx_ff   <= celx * cfg.resolution;
      my_ff   <= hm * $signed({1'b0, cfg.resolution});
      ins1_ff <= (16'(celx) < cfg.map_width) && (16'(cely) < cfg.map_height);

      c2_ff   <= c1_ff;
      ins2_ff <= ins1_ff;
      nx_ff   <= 36'(p_xc_ff >>> TRIG_SHIFT) - 36'(p_ys_ff >>> TRIG_SHIFT)
                 - 36'(cfg.origin_x);
      ny_ff   <= 36'(cfg.origin_y) - 36'(p_xs_ff >>> TRIG_SHIFT)
                 - 36'(p_yc_ff >>> TRIG_SHIFT);
      vx_ff   <= $signed({{(50-CW-31){1'b0}}, mx_ff}) + 50'(cfg.origin_x);
      vy_ff   <= my_ff + 50'(cfg.origin_y);

      c3_ff    <= c2_ff;
      ins3_ff  <= ins2_ff;
      sx_ff    <= nx_ff[35];
      sy_ff    <= ny_ff[35];
      mag_x_ff <= nx_ff[35] ? NUM_W'(-nx_ff) : NUM_W'(nx_ff);
      mag_y_ff <= ny_ff[35] ? NUM_W'(-ny_ff) : NUM_W'(ny_ff);
      q_xc_ff  <= vx_ff * cfg.cos_angle;
      q_ys_ff  <= vy_ff * cfg.sin_angle;
      q_yc_ff  <= vy_ff * cfg.cos_angle;
      q_xs_ff  <= vx_ff * cfg.sin_angle;
   end

   assign wsum_x = 52'(q_xc_ff >>> TRIG_SHIFT) + 52'(q_ys_ff >>> TRIG_SHIFT);
   assign wsum_y = 52'(q_yc_ff >>> TRIG_SHIFT) - 52'(q_xs_ff >>> TRIG_SHIFT);

   always_comb begin
      head.valid       = v3_ff;
      head.cmd         = c3_ff;
      head.sign_x      = sx_ff;
      head.sign_y      = sy_ff;
      head.inside_cell = ins3_ff;
      head.owx         = sat32(wsum_x);
      head.owy         = sat32(wsum_y);
      head.lane_x.rem  = '0;
      head.lane_x.num  = mag_x_ff;
      head.lane_y.rem  = '0;
      head.lane_y.num  = mag_y_ff;
   end

endmodule

// File: hdl/gmcc_div_cell.sv
// One restoring division cell: one quotient bit per lane, request carried along.
module gmcc_div_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic [30:0]         resolution,
   input  gmcc_pkg::stage_type stage_in,
   output gmcc_pkg::stage_type stage_out
);
   import gmcc_pkg::*;

   stage_type out_ff, out_in;

   function automatic lane_type step(input lane_type l, input logic [30:0] d);
      logic [REM_W:0] trial;
      logic           ge;
      lane_type       r;
      trial = {l.rem, l.num[NUM_W-1]};
      ge = trial >= {1'b0, d};
      r.rem = ge ? REM_W'(trial - {1'b0, d}) : trial[REM_W-1:0];
      r.num = {l.num[NUM_W-2:0], ge};
      return r;
   endfunction

   always_comb begin
      out_in = stage_in;
      out_in.lane_x = step(stage_in.lane_x, resolution);
      out_in.lane_y = step(stage_in.lane_y, resolution);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff <= out_in;
      end
   end

   assign stage_out = out_ff;

endmodule

// File: hdl/gmcc_back.sv
// Back end: quotient sign, row flip, clamping, inside tests and result register.
module gmcc_back (
   input  logic                clock,
   input  logic                reset,
   input  gmcc_pkg::cfg_type   cfg,
   input  gmcc_pkg::stage_type tail,
   output logic                rsp_valid,
   output logic signed [39:0]  rsp_out_cell_x,
   output logic signed [39:0]  rsp_out_cell_y,
   output logic signed [31:0]  rsp_out_world_x,
   output logic signed [31:0]  rsp_out_world_y,
   output logic                rsp_inside_map
);
   import gmcc_pkg::*;

   logic signed [39:0] qx, qy, cx, cy, kx, ky, w40, h40;
   logic               valid_ff;
   logic signed [39:0] ocx_ff, ocx_in, ocy_ff, ocy_in;
   logic signed [31:0] owx_ff, owx_in, owy_ff, owy_in;
   logic               ins_ff, ins_in;

   always_comb begin
      w40 = $signed(40'(cfg.map_width));
      h40 = $signed(40'(cfg.map_height));
      qx = $signed(40'(tail.lane_x.num));
      qy = $signed(40'(tail.lane_y.num));
      cx = tail.sign_x ? -qx : qx;
      cy = (tail.sign_y ? -qy : qy) + h40 - 40'sd1;
      kx = (cx < 40'sd0) ? 40'sd0 : cx;
      ky = (cy < 40'sd0) ? 40'sd0 : cy;
      if (kx >= w40) kx = w40 - 40'sd1;
      if (ky >= h40) ky = h40 - 40'sd1;
      ocx_in = '0;
      ocy_in = '0;
      owx_in = '0;
      owy_in = '0;
      ins_in = 1'b0;
      case (tail.cmd)
         CMD_W2C_CLAMP: begin
            ocx_in = kx;
            ocy_in = ky;
         end
         CMD_W2C_RAW: begin
            ocx_in = cx;
            ocy_in = cy;
         end
         CMD_C2W: begin
            owx_in = tail.owx;
            owy_in = tail.owy;
         end
         CMD_WORLD_TEST: begin
            ins_in = (cx >= 40'sd0) && (cy >= 40'sd0) && (cx < w40) && (cy < h40);
         end
         CMD_CELL_TEST: begin
            ins_in = tail.inside_cell;
         end
         default: begin
            ins_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tail.valid;
      end
      ocx_ff <= ocx_in;
      ocy_ff <= ocy_in;
      owx_ff <= owx_in;
      owy_ff <= owy_in;
      ins_ff <= ins_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_cell_x  = ocx_ff;
   assign rsp_out_cell_y  = ocy_ff;
   assign rsp_out_world_x = owx_ff;
   assign rsp_out_world_y = owy_ff;
   assign rsp_inside_map  = ins_ff;

endmodule

// File: dv/grid_map_coordinate_converter_test.sv
// Testbench of the grid map coordinate converter: directed and random requests checked against a predictor.
module grid_map_coordinate_converter_test;
   import gmcc_pkg::*;

   typedef struct {
      logic [39:0] cell_x;
      logic [39:0] cell_y;
      logic [31:0] world_x;
      logic [31:0] world_y;
      logic        in_map;
   } grid_result_type;

   class grid_scoreboard_type;
      longint origin_x, origin_y, sin_a, cos_a, res, width, height;
      grid_result_type pending[$];
      int errors;

      function new();
         origin_x = 0; origin_y = 0; sin_a = 0; cos_a = 16384;
         res = 65536; width = 1; height = 1; errors = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [31:0] v);
         case (idx)
            REG_ORIGIN_X:   origin_x = longint'(signed'(v));
            REG_ORIGIN_Y:   origin_y = longint'(signed'(v));
            REG_SIN_ANGLE:  sin_a = longint'(signed'(v[15:0]));
            REG_COS_ANGLE:  cos_a = longint'(signed'(v[15:0]));
            REG_RESOLUTION: res = longint'(v[30:0]);
            REG_MAP_WIDTH:  width = longint'(v[15:0]);
            REG_MAP_HEIGHT: height = longint'(v[15:0]);
            default: ;
         endcase
      endfunction

      function longint sat(longint v, longint lim_lo, longint lim_hi);
         return v < lim_lo ? lim_lo : (v > lim_hi ? lim_hi : v);
      endfunction

      function grid_result_type convert(logic [2:0] cmd, logic signed [31:0] wx_in,
                                        logic signed [31:0] wy_in, logic [15:0] cx_in,
                                        logic [15:0] cy_in);
         grid_result_type o;
         longint wx, wy, celx, cely, rx, ry, r, cx, cy, vx, vy, x, y, vlim;
         o = '{default: '0};
         wx = wx_in; wy = wy_in;
         celx = longint'(cx_in); cely = longint'(cy_in);
         r = (res == 0) ? 1 : res;
         vlim = (64'sd1 <<< 48) - 1;
         if (cmd == CMD_W2C_CLAMP || cmd == CMD_W2C_RAW || cmd == CMD_WORLD_TEST) begin
            rx = ((wx * cos_a) >>> 14) - ((wy * sin_a) >>> 14);
            ry = ((wx * sin_a) >>> 14) + ((wy * cos_a) >>> 14);
            cx = (rx - origin_x) / r;
            cy = (origin_y - ry) / r + height - 1;
            if (cmd == CMD_W2C_CLAMP) begin
               if (cx < 0) cx = 0;
               if (cy < 0) cy = 0;
               if (cx >= width) cx = width - 1;
               if (cy >= height) cy = height - 1;
            end
            if (cmd == CMD_WORLD_TEST) begin
               o.in_map = (cx >= 0 && cy >= 0 && cx < width && cy < height);
            end else begin
               o.cell_x = cx[39:0];
               o.cell_y = cy[39:0];
            end
         end else if (cmd == CMD_C2W) begin
            vx = sat(celx * r + origin_x, -vlim, vlim);
            vy = sat((height - 1 - cely) * r + origin_y, -vlim, vlim);
            x = ((vx * cos_a) >>> 14) + ((vy * sin_a) >>> 14);
            y = ((vy * cos_a) >>> 14) - ((vx * sin_a) >>> 14);
            o.world_x = 32'(sat(x, -64'sd2147483648, 64'sd2147483647));
            o.world_y = 32'(sat(y, -64'sd2147483648, 64'sd2147483647));
         end else if (cmd == CMD_CELL_TEST) begin
            o.in_map = (celx < width && cely < height);
         end
         return o;
      endfunction

      function void note_request(logic [2:0] cmd, logic signed [31:0] wx,
                                 logic signed [31:0] wy, logic [15:0] cx, logic [15:0] cy);
         pending.push_back(convert(cmd, wx, wy, cx, cy));
      endfunction

      function void check_response(grid_result_type act);
         grid_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response cx=%h", $time, act.cell_x);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (act.cell_x !== e.cell_x) begin
            $display("%0t: cell_x expected %h actual %h", $time, e.cell_x, act.cell_x);
            errors++;
         end
         if (act.cell_y !== e.cell_y) begin
            $display("%0t: cell_y expected %h actual %h", $time, e.cell_y, act.cell_y);
            errors++;
         end
         if (act.world_x !== e.world_x) begin
            $display("%0t: world_x expected %h actual %h", $time, e.world_x, act.world_x);
            errors++;
         end
         if (act.world_y !== e.world_y) begin
            $display("%0t: world_y expected %h actual %h", $time, e.world_y, act.world_y);
            errors++;
         end
         if (act.in_map !== e.in_map) begin
            $display("%0t: inside expected %b actual %b", $time, e.in_map, act.in_map);
            errors++;
         end
      endfunction
   endclass

   localparam int IDLE_LIMIT = 5000;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [2:0]         req_command = '0;
   logic signed [31:0] req_world_x = '0;
   logic signed [31:0] req_world_y = '0;
   logic [15:0]        req_cell_x = '0;
   logic [15:0]        req_cell_y = '0;
   logic               rsp_valid;
   logic signed [39:0] rsp_out_cell_x;
   logic signed [39:0] rsp_out_cell_y;
   logic signed [31:0] rsp_out_world_x;
   logic signed [31:0] rsp_out_world_y;
   logic               rsp_inside_map;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   grid_scoreboard_type sb = new();
   int idle_cycles = 0;

   grid_map_coordinate_converter u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (start && !busy) begin
            sb.note_request(req_command, req_world_x, req_world_y, req_cell_x, req_cell_y);
         end
         if (rsp_valid) begin
            sb.check_response('{rsp_out_cell_x, rsp_out_cell_y, rsp_out_world_x,
                                rsp_out_world_y, rsp_inside_map});
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic write_reg(reg_index_type idx, logic [31:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, v);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic write_all(logic [31:0] ox, logic [31:0] oy, int sn, int cs,
                            logic [31:0] r, logic [31:0] w, logic [31:0] h);
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_SIN_ANGLE, sn);
      write_reg(REG_COS_ANGLE, cs);
      write_reg(REG_RESOLUTION, r);
      write_reg(REG_MAP_WIDTH, w);
      write_reg(REG_MAP_HEIGHT, h);
   endtask

   task automatic send(logic [2:0] cmd, logic [31:0] wx, logic [31:0] wy,
                       logic [15:0] cx, logic [15:0] cy);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_command <= cmd;
      req_world_x <= wx;
      req_world_y <= wy;
      req_cell_x <= cx;
      req_cell_y <= cy;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic send_random();
      logic [2:0] cmd;
      longint wx, wy;
      cmd = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      if ($urandom_range(0, 2) == 0) begin
         wx = $urandom;
         wy = $urandom;
      end else begin
         wx = sb.origin_x + longint'($urandom_range(0, 32'(1 + sb.width))) * sb.res
              - longint'($urandom_range(0, 2)) * sb.res + $urandom_range(0, 255);
         wy = sb.origin_y - longint'($urandom_range(0, 32'(1 + sb.height))) * sb.res
              + longint'($urandom_range(0, 2)) * sb.res + $urandom_range(0, 255);
      end
      if ($urandom_range(0, 2) == 0) begin
         send(cmd, wx[31:0], wy[31:0], 16'($urandom), 16'($urandom));
      end else begin
         send(cmd, wx[31:0], wy[31:0], 16'($urandom_range(0, 32'(sb.width))),
              16'($urandom_range(0, 32'(sb.height))));
      end
   endtask

   initial begin
      int sn;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_all(0, 0, 0, 16384, 65536, 4, 3);
      for (int c = 0; c < 8; c++) begin
         send(3'(c), 32'h0002_8000, 32'hFFFF_0000, 16'd1, 16'd2);
      end
      send(CMD_W2C_CLAMP, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0);
      send(CMD_W2C_CLAMP, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 16'd0);
      send(CMD_W2C_RAW, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 16'd0);
      send(CMD_WORLD_TEST, 32'hFFFF_0000, 32'h0, 16'd0, 16'd0);
      send(CMD_WORLD_TEST, 32'h0, 32'h0001_0000, 16'd0, 16'd0);
      send(CMD_C2W, 0, 0, 16'hFFFF, 16'hFFFF);
      send(CMD_C2W, 0, 0, 16'h0, 16'h0);
      send(CMD_CELL_TEST, 0, 0, 16'd3, 16'd2);
      send(CMD_CELL_TEST, 0, 0, 16'd4, 16'd0);
      send(CMD_CELL_TEST, 0, 0, 16'hFFFF, 16'hFFFF);
      drain();
      write_all(32'h8000_0000, 32'h8000_0000, -16384, 0, 1, 1, 1);
      repeat (80) send_random();
      send(CMD_C2W, 0, 0, 16'hFFFF, 16'hFFFF);
      drain();
      write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16384, 16384, 32'h7FFF_FFFF, 65535, 65535);
      repeat (80) send_random();
      send(CMD_C2W, 0, 0, 16'hFFFF, 16'h0);
      drain();
      write_all(0, 0, 0, -16384, 32'h7FFF_FFFF, 65535, 1);
      repeat (40) send_random();
      drain();
      for (int p = 0; p < 5; p++) begin
         sn = $urandom_range(0, 32768) - 16384;
         write_all($urandom, $urandom, sn, $urandom_range(0, 32768) - 16384,
                   $urandom_range(1, 1 << 20), $urandom_range(1, 300),
                   $urandom_range(1, 300));
         repeat (80) send_random();
         drain();
      end
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// File: grid_map_coordinate_converter.f
hdl/gmcc_pkg.sv
hdl/gmcc_front.sv
hdl/gmcc_div_cell.sv
hdl/gmcc_back.sv
hdl/grid_map_coordinate_converter.sv
dv/grid_map_coordinate_converter_test.sv
